// ===== rtl/lbm_pkg.sv =====
// Shared types and constants for the link boot master handshake block.
package lbm_pkg;

	localparam int unsigned WORD_W   = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ID_W     = 4;
	localparam int unsigned HDR_IDX_W = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT = 1'd1;

	localparam logic [BYTE_W-1:0] PALETTE_RST     = 8'hC1;
	localparam logic [BYTE_W-1:0] PROBE_LIMIT_RST = 8'd15;

	// status codes
	localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOSLAVE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ACKERR  = 2'd3;

	// command words and reply prefixes
	localparam logic [WORD_W-1:0] CMD_PROBE   = 16'h6200;
	localparam logic [11:0]       CMD_ACK_HI  = 12'h610;
	localparam logic [11:0]       CMD_SYNC_HI = 12'h620;
	localparam logic [7:0]        CMD_PAL_HI  = 8'h63;
	localparam logic [7:0]        CMD_HS_HI   = 8'h64;
	localparam logic [11:0]       RSP_ID_HI   = 12'h720;
	localparam logic [7:0]        RSP_PAL_HI  = 8'h73;
	// 0x11 + 0xff + 0xff folds to this offset mod 256
	localparam logic [BYTE_W-1:0] HS_OFFSET   = 8'h0F;

	typedef enum logic [3:0] {
		PH_IDLE, PH_WAITZERO, PH_PROBE, PH_ACK1, PH_HEADER, PH_ACK2,
		PH_ACK3, PH_PALETTE, PH_HANDSHAKE, PH_DONE, PH_NOSLAVE, PH_ACKERR
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic [BYTE_W-1:0]     probe_cnt;
		logic [ID_W-1:0]       slave;
		logic [HDR_IDX_W-1:0]  hdr_pos;
		logic [BYTE_W-1:0]     client;
		logic [BYTE_W-1:0]     hshake;
	} lbm_state_t;

	typedef struct packed {
		logic [WORD_W-1:0]    tx_word;
		logic                 tx_valid;
		logic [STATUS_W-1:0]  status;
		logic [ID_W-1:0]      slave_id;
		logic [HDR_IDX_W-1:0] header_index;
		logic [BYTE_W-1:0]    client_value;
		logic [BYTE_W-1:0]    handshake_value;
	} lbm_result_t;

endpackage

// ===== rtl/lbm_if.sv =====
// Valid/ready channel interfaces for input items and results.
interface lbm_item_if;
	logic        valid;
	logic        ready;
	logic        start_req;
	logic [15:0] rx_word;
	logic [15:0] header_word;

	modport source (output valid, start_req, rx_word, header_word, input ready);
	modport sink   (input valid, start_req, rx_word, header_word, output ready);
endinterface

interface lbm_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] tx_word;
	logic        tx_valid;
	logic [1:0]  status;
	logic [3:0]  slave_id;
	logic [6:0]  header_index;
	logic [7:0]  client_value;
	logic [7:0]  handshake_value;

	modport source (output valid, tx_word, tx_valid, status, slave_id, header_index,
		client_value, handshake_value, input ready);
	modport sink   (input valid, tx_word, tx_valid, status, slave_id, header_index,
		client_value, handshake_value, output ready);
endinterface

// ===== rtl/lbm_step.sv =====
// Next-state and result logic for one link transfer.
module lbm_step #(
	parameter int unsigned HEADER_WORDS = 96
) (
	input  lbm_pkg::lbm_state_t  cur,
	input  logic                 start_req,
	input  logic [15:0]          rx_word,
	input  logic [15:0]          header_word,
	input  logic [7:0]           palette,
	input  logic [7:0]           probe_limit,
	output lbm_pkg::lbm_state_t  nxt,
	output lbm_pkg::lbm_result_t res
);
	import lbm_pkg::*;

	localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_WORDS);

	logic [WORD_W-1:0]    tx;
	logic                 vld;
	logic [BYTE_W-1:0]    limit;
	logic [BYTE_W-1:0]    cnt_inc;
	logic [BYTE_W-1:0]    hs;
	logic [STATUS_W-1:0]  st;

	assign limit   = (probe_limit == '0) ? BYTE_W'(1) : probe_limit;
	assign cnt_inc = cur.probe_cnt + BYTE_W'(1);
	assign hs      = rx_word[7:0] + HS_OFFSET;

	always_comb begin
		nxt = cur;
		tx  = '0;
		vld = 1'b0;
		if (start_req) begin
			nxt       = '0;
			nxt.phase = PH_WAITZERO;
			tx        = CMD_PROBE;
			vld       = 1'b1;
		end else begin
			unique case (cur.phase)
				PH_WAITZERO: begin
					if (rx_word == '0)
						nxt.phase = PH_PROBE;
					tx  = CMD_PROBE;
					vld = 1'b1;
				end
				PH_PROBE: begin
					if (rx_word[15:4] == RSP_ID_HI) begin
						nxt.slave = rx_word[3:0];
						nxt.phase = PH_ACK1;
						tx        = {CMD_ACK_HI, rx_word[3:0]};
						vld       = 1'b1;
					end else begin
						nxt.probe_cnt = cnt_inc;
						if (cnt_inc >= limit) begin
							nxt.phase = PH_NOSLAVE;
						end else begin
							tx  = CMD_PROBE;
							vld = 1'b1;
						end
					end
				end
				PH_ACK1: begin
					if (rx_word == {RSP_ID_HI, cur.slave}) begin
						nxt.phase   = PH_HEADER;
						nxt.hdr_pos = HDR_IDX_W'(1);
						tx          = header_word;
						vld         = 1'b1;
					end else begin
						nxt.phase = PH_ACKERR;
					end
				end
				PH_HEADER: begin
					if (cur.hdr_pos < HDR_LAST) begin
						tx          = header_word;
						nxt.hdr_pos = cur.hdr_pos + HDR_IDX_W'(1);
					end else begin
						nxt.phase = PH_ACK2;
						tx        = CMD_PROBE;
					end
					vld = 1'b1;
				end
				PH_ACK2: begin
					if (rx_word == {12'h000, cur.slave}) begin
						nxt.phase = PH_ACK3;
						tx        = {CMD_SYNC_HI, cur.slave};
						vld       = 1'b1;
					end else begin
						nxt.phase = PH_ACKERR;
					end
				end
				PH_ACK3: begin
					if (rx_word == {RSP_ID_HI, cur.slave}) begin
						nxt.phase = PH_PALETTE;
						tx        = {CMD_PAL_HI, palette};
						vld       = 1'b1;
					end else begin
						nxt.phase = PH_ACKERR;
					end
				end
				PH_PALETTE: begin
					if (rx_word[15:8] == RSP_PAL_HI) begin
						nxt.client = rx_word[7:0];
						nxt.hshake = hs;
						nxt.phase  = PH_HANDSHAKE;
						tx         = {CMD_HS_HI, hs};
					end else begin
						tx = {CMD_PAL_HI, palette};
					end
					vld = 1'b1;
				end
				PH_HANDSHAKE: begin
					nxt.phase = (rx_word[15:8] == RSP_PAL_HI) ? PH_DONE : PH_ACKERR;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (nxt.phase)
			PH_DONE:    st = ST_DONE;
			PH_NOSLAVE: st = ST_NOSLAVE;
			PH_ACKERR:  st = ST_ACKERR;
			default:    st = ST_BUSY;
		endcase
	end

	assign res.tx_word         = vld ? tx : '0;
	assign res.tx_valid        = vld;
	assign res.status          = st;
	assign res.slave_id        = nxt.slave;
	assign res.header_index    = nxt.hdr_pos;
	assign res.client_value    = nxt.client;
	assign res.handshake_value = nxt.hshake;

endmodule

// ===== rtl/link_boot_master_handshake_top.sv =====
// Master side of a 16-bit multiplayer-link boot handshake.
//
// Channels: "item" carries one beat per completed link transfer (start_req,
// the word received in that transfer and the header halfword at the index
// last reported). "result" returns one beat per item: the next word to send,
// tx_valid, status and the progress fields. A start beat restarts the
// sequence from the wait-for-zero phase whatever the current phase.
// Configuration: cfg_we/cfg_index/cfg_data write palette_value (index 0)
// or probe_limit (index 1); write only while no result is outstanding.
// Result timing: a result appears in the cycle after its item is taken.
// Throughput: one item per cycle while result.ready is high; the state update
// and result word are combinational compare/add logic into their registers.
// Stall: the result register holds while result.ready is low; item.ready
// then drops, so no beat is lost. item.ready = result register empty or
// being drained this cycle.
// Reset: arst_n clears the phase to idle, progress to zero, the result
// register to empty, and loads palette 0xC1 and probe limit 15.
module link_boot_master_handshake_top #(
	parameter int unsigned HEADER_WORDS = 96
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbm_pkg::BYTE_W-1:0]      cfg_data,
	lbm_item_if.sink                        item,
	lbm_result_if.source                    result
);
	import lbm_pkg::*;

	lbm_state_t  state_q;
	lbm_state_t  state_nxt;
	lbm_result_t res_nxt;
	lbm_result_t res_q;
	logic        res_valid_q;
	logic [BYTE_W-1:0] palette_q;
	logic [BYTE_W-1:0] limit_q;
	logic        accept;

	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q <= PALETTE_RST;
			limit_q   <= PROBE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PALETTE:     palette_q <= cfg_data;
				CFG_PROBE_LIMIT: limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	lbm_step #(
		.HEADER_WORDS(HEADER_WORDS)
	) u_step (
		.cur         (state_q),
		.start_req   (item.start_req),
		.rx_word     (item.rx_word),
		.header_word (item.header_word),
		.palette     (palette_q),
		.probe_limit (limit_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (accept) begin
			state_q     <= state_nxt;
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_nxt;
	end

	assign result.valid           = res_valid_q;
	assign result.tx_word         = res_q.tx_word;
	assign result.tx_valid        = res_q.tx_valid;
	assign result.status          = res_q.status;
	assign result.slave_id        = res_q.slave_id;
	assign result.header_index    = res_q.header_index;
	assign result.client_value    = res_q.client_value;
	assign result.handshake_value = res_q.handshake_value;

	// a word to send only goes out while the handshake is still running
	a_tx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.tx_valid |-> res_q.status == ST_BUSY)
		else $error("tx word flagged with final status");

	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.tx_valid |-> res_q.tx_word == '0)
		else $error("tx word not zero when nothing to send");

	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hdr_pos <= HDR_IDX_W'(HEADER_WORDS))
		else $error("header position past header length");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.start_req |=> state_q.phase == PH_WAITZERO)
		else $error("start beat did not restart handshake");

	a_final_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_DONE || state_q.phase == PH_NOSLAVE ||
		 state_q.phase == PH_ACKERR) && !(accept && item.start_req)
		|=> $stable(state_q.phase))
		else $error("final phase left without start");

endmodule
